// ===== rtl/core/apss_pkg.sv =====
package apss_pkg;

  // Field widths of the item formats.
  localparam int TOTAL_W  = 13;
  localparam int POS_W    = 16;
  localparam int FILL_W   = 12;
  localparam int TOL_W    = 8;
  localparam int FBYTES_W = 7;
  localparam int BYTES_W  = 19;
  localparam int INDEX_W  = 6;
  localparam int ACC_W    = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_EXP_EVEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_ODD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FBYTES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP      = 3'd4;

  // Register values after reset.
  localparam logic [FILL_W-1:0]   RST_EXP_EVEN  = 12'd221;
  localparam logic [FILL_W-1:0]   RST_EXP_ODD   = 12'd220;
  localparam logic [TOL_W-1:0]    RST_TOLERANCE = 8'd10;
  localparam logic [FBYTES_W-1:0] RST_FBYTES    = 7'd12;
  localparam logic [POS_W-1:0]    RST_WRAP      = 16'd44100;

  // Operation codes of an input beat.
  localparam logic OP_FEEDBACK = 1'b0;
  localparam logic OP_FILL     = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] feedback_count;
  } in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] packet_index;
    logic [TOTAL_W-1:0] packet_frames;
    logic [BYTES_W-1:0] packet_bytes;
    logic [POS_W-1:0]   start_position;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [FILL_W-1:0]   expected_fill_even;
    logic [FILL_W-1:0]   expected_fill_odd;
    logic [TOL_W-1:0]    fill_tolerance;
    logic [FBYTES_W-1:0] frame_bytes;
    logic [POS_W-1:0]    position_wrap;
  } cfg_t;

  // One planned transfer handed from the front to the back.
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [POS_W-1:0]   start;
  } xfer_t;

endpackage

// ===== rtl/core/apss_rem_serial.sv =====
module apss_rem_serial #(
  parameter int NW = 13,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  // One quotient bit per cycle: shift the next dividend bit in, subtract if it fits.
  always_comb begin
    trial   = {rem_r, q_r[NW-1]};
    diff    = trial - {1'b0, den_r};
    fits    = (trial >= {1'b0, den_r});
    rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= {q_r[NW-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/core/apss_fifo2.sv =====
module apss_fifo2 (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  apss_pkg::xfer_t wdata,
  input  logic           pop,
  output apss_pkg::xfer_t rdata,
  output logic           full,
  output logic           empty
);
  import apss_pkg::*;

  xfer_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);

endmodule

// ===== rtl/core/apss_front.sv =====
module apss_front (
  input  logic            clk,
  input  logic            rst_n,
  input  apss_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  apss_pkg::in_t   in_data,
  input  logic            q_full,
  output logic            q_push,
  output apss_pkg::xfer_t q_wdata
);
  import apss_pkg::*;

  localparam logic [1:0] FE_IDLE = 2'd0;
  localparam logic [1:0] FE_PUSH = 2'd1;
  localparam logic [1:0] FE_MOD  = 2'd2;

  logic [1:0]         st_r;
  logic [ACC_W-1:0]   acc_r;
  logic               phase_r;
  logic [POS_W-1:0]   pos_r;
  logic [TOTAL_W-1:0] total_r;

  logic               accept;
  logic [ACC_W:0]     acc_sum;
  logic [FILL_W-1:0]  expected;
  logic signed [17:0] acc_s;
  logic signed [17:0] lo_s;
  logic signed [17:0] hi_s;
  logic               off_window;
  logic [TOTAL_W-1:0] total_c;
  logic [POS_W:0]     pos_sum;
  logic [POS_W:0]     wrap_den;
  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [POS_W:0]     div_rem;

  assign in_ready = (st_r == FE_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;

  // Saturating accumulation of feedback counts.
  assign acc_sum = {1'b0, acc_r} + {{(ACC_W - 7){1'b0}}, in_data.feedback_count};

  // Frame total: the accumulator inside the expected window, else the expected fill.
  always_comb begin
    expected   = phase_r ? cfg.expected_fill_odd : cfg.expected_fill_even;
    acc_s      = $signed({2'b00, acc_r});
    lo_s       = $signed({6'b0, expected}) - $signed({10'b0, cfg.fill_tolerance});
    hi_s       = $signed({6'b0, expected}) + $signed({10'b0, cfg.fill_tolerance});
    off_window = (acc_s < lo_s) || (acc_s > hi_s);
    total_c    = off_window ? {1'b0, expected} : acc_r[TOTAL_W-1:0];
  end

  // Position advance, reduced modulo the wrap; a zero wrap means a full 16-bit wrap.
  assign pos_sum   = {1'b0, pos_r} + {{(POS_W + 1 - TOTAL_W){1'b0}}, total_r};
  assign wrap_den  = (cfg.position_wrap == '0) ? {1'b1, {POS_W{1'b0}}}
                                               : {1'b0, cfg.position_wrap};
  assign div_start = (st_r == FE_PUSH);

  apss_rem_serial #(
    .NW(POS_W + 1),
    .DW(POS_W + 1)
  ) u_pos_rem (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (pos_sum),
    .den  (wrap_den),
    .busy (div_busy),
    .done (div_done),
    .rem  (div_rem)
  );

  // Hand the planned transfer to the queue with the position before the advance.
  assign q_push        = (st_r == FE_PUSH);
  assign q_wdata.total = total_r;
  assign q_wdata.start = pos_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= FE_IDLE;
      acc_r   <= '0;
      phase_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      case (st_r)
        FE_IDLE: begin
          if (accept) begin
            if (in_data.op == OP_FILL) begin
              acc_r   <= '0;
              phase_r <= ~phase_r;
              st_r    <= FE_PUSH;
            end else begin
              acc_r <= acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
            end
          end
        end
        FE_PUSH: begin
          st_r <= FE_MOD;
        end
        FE_MOD: begin
          if (div_done && !div_busy) begin
            pos_r <= div_rem[POS_W-1:0];
            st_r  <= FE_IDLE;
          end
        end
        default: begin
          st_r <= FE_IDLE;
        end
      endcase
    end
  end

  // Latched frame total of the request in flight.
  always_ff @(posedge clk) begin
    if (accept && (in_data.op == OP_FILL)) begin
      total_r <= total_c;
    end
  end

endmodule

// ===== rtl/core/apss_back.sv =====
module apss_back #(
  parameter int PACKETS = 40
) (
  input  logic            clk,
  input  logic            rst_n,
  input  apss_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  apss_pkg::xfer_t q_rdata,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output apss_pkg::out_t  out_data
);
  import apss_pkg::*;

  localparam int PW = $clog2(PACKETS + 1);
  localparam logic [PW-1:0] PKT_CNT = PW'(PACKETS);

  // Scaled reciprocal of PACKETS, exact for every total that fits TOTAL_W bits.
  localparam int RECIP_SH = TOTAL_W + $clog2(PACKETS);
  localparam int RECIP_W  = TOTAL_W + 2;
  localparam int PROD_W   = TOTAL_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << RECIP_SH) + PACKETS - 1) / PACKETS);

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_DIV  = 2'd1;
  localparam logic [1:0] BK_EMIT = 2'd2;

  logic [1:0]         st_r;
  logic [POS_W-1:0]   start_r;
  logic [TOTAL_W-1:0] total_r;
  logic [TOTAL_W-1:0] base_r;
  logic [PW-1:0]      frac_r;
  logic [PW-1:0]      err_r;
  logic [PW-1:0]      err_nxt;
  logic [INDEX_W-1:0] idx_r;
  logic               out_valid_r;
  out_t               out_r;

  logic [PROD_W-1:0]  prod_c;
  logic [TOTAL_W-1:0] quot_c;
  logic [TOTAL_W-1:0] share;
  logic [TOTAL_W-1:0] rem_c;
  logic [PW:0]        err_sum;
  logic               carry;
  logic [TOTAL_W-1:0] frames;
  logic [19:0]        bytes_full;
  logic               adv;
  logic               is_last;

  assign q_pop = (st_r == BK_IDLE) && !q_empty;

  // Split the total into a base share per packet and a remainder to spread:
  // the quotient comes from a reciprocal multiply, the remainder from the registered quotient.
  always_comb begin
    prod_c = q_rdata.total * RECIP;
    quot_c = TOTAL_W'(prod_c >> RECIP_SH);
    share  = base_r * TOTAL_W'(PACKETS);
    rem_c  = total_r - share;
  end

  // Running error term: a packet gets one extra frame whenever it overflows.
  always_comb begin
    err_sum    = {1'b0, err_r} + {1'b0, frac_r};
    carry      = (err_sum >= {1'b0, PKT_CNT});
    err_nxt    = carry ? PW'(err_sum - {1'b0, PKT_CNT}) : err_sum[PW-1:0];
    frames     = base_r + {{(TOTAL_W - 1){1'b0}}, carry};
    bytes_full = frames * cfg.frame_bytes;
    adv        = (st_r == BK_EMIT) && (!out_valid_r || out_ready);
    is_last    = (idx_r == INDEX_W'(PACKETS - 1));
  end

  // Sequencer and output beat valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        BK_IDLE: begin
          if (q_pop) begin
            st_r <= BK_DIV;
          end
        end
        BK_DIV: begin
          st_r <= BK_EMIT;
        end
        BK_EMIT: begin
          if (adv && is_last) begin
            st_r <= BK_IDLE;
          end
        end
        default: begin
          st_r <= BK_IDLE;
        end
      endcase
    end
  end

  // Per-transfer datapath.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      start_r <= q_rdata.start;
      total_r <= q_rdata.total;
      base_r  <= quot_c;
    end
    if (st_r == BK_DIV) begin
      frac_r <= rem_c[PW-1:0];
      err_r  <= '0;
      idx_r  <= '0;
    end else if (adv) begin
      err_r <= err_nxt;
      idx_r <= idx_r + 1'b1;
    end
    if (adv) begin
      out_r.packet_index   <= idx_r;
      out_r.packet_frames  <= frames;
      out_r.packet_bytes   <= bytes_full[BYTES_W-1:0];
      out_r.start_position <= start_r;
      out_r.last           <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/audio_packet_size_scheduler.sv =====
// Channel  Ports                            Carries
// -------  -------------------------------  -----------------------------------------
// in       in_valid in_ready in_data         feedback report or fill request beat
// out      out_valid out_ready out_data      one packet size beat, PACKETS per fill
// cfg      cfg_valid cfg_ready cfg_index     register write, always ready
//          cfg_data
//
// A feedback beat leaves the front ready for the next beat; a fill request holds the front
// busy through the 17-step serial modulo that advances the play position.
// The back splits a transfer into shares in its pop and divide states, then emits PACKETS
// beats at one per cycle while out_ready is high, and pops a new transfer only when idle.
// A two-entry queue lets the front plan the next transfer while the back still emits.
// Reset is synchronous; out_ready low stalls the back, and a full queue stalls the input.
module audio_packet_size_scheduler #(
  parameter int PACKETS = 40
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  apss_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output apss_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [apss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [apss_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import apss_pkg::*;

  cfg_t  cfg_r;
  logic  q_full;
  logic  q_empty;
  logic  q_push;
  logic  q_pop;
  xfer_t q_wdata;
  xfer_t q_rdata;

  assign cfg_ready = 1'b1;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_fill_even <= RST_EXP_EVEN;
      cfg_r.expected_fill_odd  <= RST_EXP_ODD;
      cfg_r.fill_tolerance     <= RST_TOLERANCE;
      cfg_r.frame_bytes        <= RST_FBYTES;
      cfg_r.position_wrap      <= RST_WRAP;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EXP_EVEN:  cfg_r.expected_fill_even <= cfg_data[FILL_W-1:0];
        REG_EXP_ODD:   cfg_r.expected_fill_odd  <= cfg_data[FILL_W-1:0];
        REG_TOLERANCE: cfg_r.fill_tolerance     <= cfg_data[TOL_W-1:0];
        REG_FBYTES:    cfg_r.frame_bytes        <= cfg_data[FBYTES_W-1:0];
        REG_WRAP:      cfg_r.position_wrap      <= cfg_data[POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  apss_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  apss_fifo2 u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  apss_back #(
    .PACKETS(PACKETS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
